// ===== hdl/tiny_16bit_cpu_step_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stepped 16-bit core
// Clocked property wrappers with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef TINY_16BIT_CPU_STEP_CORE_MACROS_SVH
`define TINY_16BIT_CPU_STEP_CORE_MACROS_SVH

// same-cycle implication
`define T16_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define T16_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== hdl/t16cpu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// t16cpu_pkg
// Shared types, codes and constants of the stepped 16-bit core.
// ---------------------------------------------------------------------------
package t16cpu_pkg;

	localparam int WORD_W      = 16;
	localparam int STEP_W      = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 88;

	localparam logic [STEP_W-1:0] MAX_STEPS_RST = 32'd100000;
	localparam logic [2:0]        FLAG_Z        = 3'b100;
	localparam logic [2:0]        FLAG_N        = 3'b010;
	localparam logic [2:0]        FLAG_P        = 3'b001;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_EXEC  = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic [3:0] {
		OP_HALT  = 4'd0,
		OP_ADD   = 4'd1,
		OP_AND   = 4'd2,
		OP_NOT   = 4'd3,
		OP_JZ    = 4'd4,
		OP_JMP   = 4'd5,
		OP_LOADI = 4'd6,
		OP_MUL   = 4'd7,
		OP_SUBI  = 4'd8,
		OP_STORE = 4'd9,
		OP_LOADM = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_HALT    = 3'd1,
		ST_BAD_OP  = 3'd2,
		ST_LIMIT   = 3'd3,
		ST_STOPPED = 3'd4
	} status_t;

	typedef struct packed {
		logic              wb_en;
		logic [WORD_W-1:0] wb_value;
		logic              store_en;
		logic              halt;
		logic              bad_op;
		logic [WORD_W-1:0] pc_next;
	} alu_res_t;

	function automatic logic [2:0] flags_of(input logic [WORD_W-1:0] v);
		logic [2:0] f;
		if (v == '0) begin
			f = FLAG_Z;
		end else if (v[WORD_W-1]) begin
			f = FLAG_N;
		end else begin
			f = FLAG_P;
		end
		return f;
	endfunction

endpackage

// ===== hdl/tiny_16bit_cpu_step_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiny_16bit_cpu_step_core
// Stepped 16-bit core. Each input transfer writes a memory word, reads a
// register or executes one instruction, and yields one result transfer.
// An item passes stage 1 and stage 2 before its result is registered, and
// the next item is accepted at the edge that registers the previous
// result, so no new item enters before the last one commits; a stalled
// output holds the commit. The stages come from the main memory's single
// read port: the instruction is fetched at acceptance, then the operand
// registers and the LOADM data word are read, then the item commits.
// After reset the main memory is swept to zero before the first item is
// accepted; writes to max_steps are taken at any time.
// ---------------------------------------------------------------------------
module tiny_16bit_cpu_step_core #(
	parameter int ADDR_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [t16cpu_pkg::STEP_W-1:0]         cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// mem_addr[15:0], mem_data[31:16], reg_index[34:32], zero pad[39:35]
	input  logic [t16cpu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// req_type[1:0]
	input  logic [t16cpu_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pc_before[15:0], instr_word[31:16], value[47:32], status[50:48],
	// flags_znp[53:51], step_count[85:54], zero pad[87:86]
	output logic [t16cpu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam int W = t16cpu_pkg::WORD_W;

	logic                 busy;
	logic                 accept;
	logic                 commit;

	logic                 s1_valid;
	t16cpu_pkg::req_t     req_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [W-1:0]         data_s1;
	logic [2:0]           ridx_s1;

	logic                 s2_valid;
	t16cpu_pkg::req_t     req_s2;
	logic [W-1:0]         instr_s2;

	logic [W-1:0]                  pc_q;
	logic [2:0]                    flags_q;
	logic [t16cpu_pkg::STEP_W-1:0] steps_q;
	logic                          stopped_q;
	logic [t16cpu_pkg::STEP_W-1:0] max_steps_q;

	logic [W-1:0]                  pc_d;
	logic [2:0]                    flags_d;
	logic [t16cpu_pkg::STEP_W-1:0] steps_d;
	logic                          stopped_d;
	logic [W-1:0]                  res_pc;
	logic [W-1:0]                  res_instr;
	logic [W-1:0]                  res_value;
	t16cpu_pkg::status_t           res_status;
	logic                          rf_we;
	logic                          st_we;

	logic                 out_valid_q;
	logic [t16cpu_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [W-1:0]         mem_rd_data;
	logic                 mem_wr_en;
	logic [ADDR_BITS-1:0] mem_wr_addr;
	logic [W-1:0]         mem_wr_data;
	logic                 mem_rd_en;
	logic [ADDR_BITS-1:0] mem_rd_addr;
	logic [W-1:0]         fetch_pc;
	logic [W-1:0]         instr_w;

	logic [2:0]           rf_addr_a;
	logic [W-1:0]         rf_a;
	logic [W-1:0]         rf_b;

	t16cpu_pkg::alu_res_t alu;

	assign cfg_ready     = 1'b1;
	assign commit        = s2_valid && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !busy && !s1_valid && (!s2_valid || commit);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign instr_w       = mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= t16cpu_pkg::MAX_STEPS_RST;
		end else if (cfg_valid) begin
			max_steps_q <= cfg_data;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
			if (s1_valid) begin
				s2_valid <= 1'b1;
			end else if (commit) begin
				s2_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= t16cpu_pkg::req_t'(s_axis_tuser);
			addr_s1 <= s_axis_tdata[ADDR_BITS-1:0];
			data_s1 <= s_axis_tdata[31:16];
			ridx_s1 <= s_axis_tdata[34:32];
		end
		if (s1_valid) begin
			req_s2   <= req_s1;
			instr_s2 <= instr_w;
		end
	end

	// main memory: fetch at acceptance, LOADM read in stage 1
	assign fetch_pc    = commit ? pc_d : pc_q;
	assign mem_rd_en   = accept || (s1_valid && (req_s1 == t16cpu_pkg::REQ_EXEC));
	assign mem_rd_addr = s1_valid ? ADDR_BITS'(instr_w[5:0]) : fetch_pc[ADDR_BITS-1:0];
	assign mem_wr_en   = (s1_valid && (req_s1 == t16cpu_pkg::REQ_WRITE)) || (commit && st_we);
	assign mem_wr_addr = s1_valid ? addr_s1 : ADDR_BITS'(instr_s2[5:0]);
	assign mem_wr_data = s1_valid ? data_s1 : rf_a;

	t16cpu_mem #(
		.ADDR_BITS(ADDR_BITS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (mem_rd_en),
		.rd_addr   (mem_rd_addr),
		.rd_data   (mem_rd_data),
		.clear_busy(busy)
	);

	assign rf_addr_a = (req_s1 == t16cpu_pkg::REQ_READ) ? ridx_s1 : instr_w[11:9];

	t16cpu_rf u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (s1_valid),
		.addr_a (rf_addr_a),
		.addr_b (instr_w[8:6]),
		.rd_a   (rf_a),
		.rd_b   (rf_b),
		.wr_en  (commit && rf_we),
		.wr_addr(instr_s2[11:9]),
		.wr_data(res_value)
	);

	t16cpu_alu u_alu (
		.instr(instr_s2),
		.a    (rf_a),
		.b    (rf_b),
		.mdata(mem_rd_data),
		.pc   (pc_q),
		.res  (alu)
	);

	// stage 2 resolve
	always_comb begin
		pc_d       = pc_q;
		flags_d    = flags_q;
		steps_d    = steps_q;
		stopped_d  = stopped_q;
		res_pc     = '0;
		res_instr  = '0;
		res_value  = '0;
		res_status = t16cpu_pkg::ST_DONE;
		rf_we      = 1'b0;
		st_we      = 1'b0;
		unique case (req_s2)
			t16cpu_pkg::REQ_READ: begin
				res_value = rf_a;
			end
			t16cpu_pkg::REQ_EXEC: begin
				if (stopped_q) begin
					res_status = t16cpu_pkg::ST_STOPPED;
				end else if (steps_q >= max_steps_q) begin
					stopped_d  = 1'b1;
					res_status = t16cpu_pkg::ST_LIMIT;
				end else begin
					res_pc    = pc_q;
					res_instr = instr_s2;
					pc_d      = alu.pc_next;
					st_we     = alu.store_en;
					if (alu.wb_en) begin
						rf_we     = 1'b1;
						res_value = alu.wb_value;
						flags_d   = t16cpu_pkg::flags_of(alu.wb_value);
					end
					if (alu.halt) begin
						stopped_d  = 1'b1;
						res_status = t16cpu_pkg::ST_HALT;
					end else if (alu.bad_op) begin
						stopped_d  = 1'b1;
						res_status = t16cpu_pkg::ST_BAD_OP;
					end else begin
						steps_d = steps_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			flags_q   <= t16cpu_pkg::FLAG_Z;
			steps_q   <= '0;
			stopped_q <= 1'b0;
		end else if (commit) begin
			pc_q      <= pc_d;
			flags_q   <= flags_d;
			steps_q   <= steps_d;
			stopped_q <= stopped_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {2'b00, steps_d, flags_d, res_status, res_value, res_instr, res_pc};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/t16cpu_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// t16cpu_mem
// Main word memory: one write and one registered read port, write-first
// on a same-address collision, swept to zero after reset.
// ---------------------------------------------------------------------------
module t16cpu_mem #(
	parameter int ADDR_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ADDR_BITS-1:0]         wr_addr,
	input  logic [t16cpu_pkg::WORD_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [ADDR_BITS-1:0]         rd_addr,
	output logic [t16cpu_pkg::WORD_W-1:0] rd_data,
	output logic                         clear_busy
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [t16cpu_pkg::WORD_W-1:0] mem [DEPTH];
	logic [ADDR_BITS-1:0]          clr_addr_q;
	logic                          busy_q;
	logic                          we;
	logic [ADDR_BITS-1:0]          waddr;
	logic [t16cpu_pkg::WORD_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign we    = busy_q || wr_en;
	assign waddr = busy_q ? clr_addr_q : wr_addr;
	assign wdata = busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data <= (we && (waddr == rd_addr)) ? wdata : mem[rd_addr];
		end
	end

	assign clear_busy = busy_q;

endmodule

// ===== hdl/t16cpu_rf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// t16cpu_rf
// Eight-entry register file: two registered read ports, one write port,
// per-entry valid bits so unwritten registers read as zero.
// ---------------------------------------------------------------------------
module t16cpu_rf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [2:0]                    addr_a,
	input  logic [2:0]                    addr_b,
	output logic [t16cpu_pkg::WORD_W-1:0] rd_a,
	output logic [t16cpu_pkg::WORD_W-1:0] rd_b,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_addr,
	input  logic [t16cpu_pkg::WORD_W-1:0] wr_data
);

	logic [t16cpu_pkg::WORD_W-1:0] regs [8];
	logic [7:0]                    vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a <= vld_q[addr_a] ? regs[addr_a] : '0;
			rd_b <= vld_q[addr_b] ? regs[addr_b] : '0;
		end
	end

endmodule

// ===== hdl/t16cpu_alu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// t16cpu_alu
// Instruction decode and execute: write-back value, store request, stop
// conditions and next program counter.
// ---------------------------------------------------------------------------
module t16cpu_alu (
	input  logic [t16cpu_pkg::WORD_W-1:0] instr,
	input  logic [t16cpu_pkg::WORD_W-1:0] a,
	input  logic [t16cpu_pkg::WORD_W-1:0] b,
	input  logic [t16cpu_pkg::WORD_W-1:0] mdata,
	input  logic [t16cpu_pkg::WORD_W-1:0] pc,
	output t16cpu_pkg::alu_res_t           res
);

	t16cpu_pkg::op_t               op;
	logic [t16cpu_pkg::WORD_W-1:0] imm;
	logic [t16cpu_pkg::WORD_W-1:0] pc_inc;

	assign op     = t16cpu_pkg::op_t'(instr[15:12]);
	assign imm    = {10'd0, instr[5:0]};
	assign pc_inc = pc + 16'd1;

	always_comb begin
		res          = '0;
		res.pc_next  = pc_inc;
		unique case (op)
			t16cpu_pkg::OP_HALT: begin
				res.halt = 1'b1;
			end
			t16cpu_pkg::OP_ADD: begin
				res.wb_en    = 1'b1;
				res.wb_value = a + b;
			end
			t16cpu_pkg::OP_AND: begin
				res.wb_en    = 1'b1;
				res.wb_value = a & b;
			end
			t16cpu_pkg::OP_NOT: begin
				res.wb_en    = 1'b1;
				res.wb_value = ~b;
			end
			t16cpu_pkg::OP_JZ: begin
				if (a == '0) begin
					res.pc_next = pc_inc + imm;
				end
			end
			t16cpu_pkg::OP_JMP: begin
				res.pc_next = a;
			end
			t16cpu_pkg::OP_LOADI: begin
				res.wb_en    = 1'b1;
				res.wb_value = imm;
			end
			t16cpu_pkg::OP_MUL: begin
				res.wb_en    = 1'b1;
				res.wb_value = a * b;
			end
			t16cpu_pkg::OP_SUBI: begin
				res.wb_en    = 1'b1;
				res.wb_value = a - imm;
			end
			t16cpu_pkg::OP_STORE: begin
				res.store_en = 1'b1;
			end
			t16cpu_pkg::OP_LOADM: begin
				res.wb_en    = 1'b1;
				res.wb_value = mdata;
			end
			default: begin
				res.bad_op = 1'b1;
			end
		endcase
	end

endmodule

// ===== hdl/t16cpu_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// t16cpu_chk
// Port-level checks of the stepped 16-bit core, bound to the top level.
// ---------------------------------------------------------------------------
`include "tiny_16bit_cpu_step_core_macros.svh"

module t16cpu_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [t16cpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// stalled result holds
	`T16_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// one item in flight: input drops ready after an acceptance
	`T16_ASSERT_NXT(a_in_gap, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// stopped core reports no pc or instruction
	`T16_ASSERT_IMP(a_stop_quiet, clk, arst_n, m_axis_tvalid && (m_axis_tdata[50:48] == t16cpu_pkg::ST_STOPPED), m_axis_tdata[31:0] == 32'd0)

	// any stop status writes no register
	`T16_ASSERT_IMP(a_stat_nowb, clk, arst_n, m_axis_tvalid && (m_axis_tdata[50:48] != t16cpu_pkg::ST_DONE), m_axis_tdata[47:32] == 16'd0)

endmodule

bind tiny_16bit_cpu_step_core t16cpu_chk u_chk (.*);
